// ===== rtl/bca_pkg.sv =====
package bca_pkg;

    localparam int TICK_BITS    = 32;
    localparam int HOLD_BITS    = 16;
    localparam int CFG_BITS     = 16;
    localparam int CNT_BITS     = 16;
    localparam int CD_BITS      = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int DIV_CNT_BITS = $clog2(CNT_BITS);
    localparam int HCMP_BITS    = (HOLD_BITS > CFG_BITS) ? HOLD_BITS : CFG_BITS;

    localparam logic [CFG_BITS-1:0] DC_WINDOW_RST   = CFG_BITS'(70);
    localparam logic [CFG_BITS-1:0] HOLD_DELAY_RST  = CFG_BITS'(250);
    localparam logic [CFG_BITS-1:0] REPEAT_BASE_RST = CFG_BITS'(500);
    localparam logic [CFG_BITS-1:0] REPEAT_MIN_RST  = CFG_BITS'(1);

    localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DC_WINDOW   = CFG_IDX_BITS'(0),
        REG_HOLD_DELAY  = CFG_IDX_BITS'(1),
        REG_REPEAT_BASE = CFG_IDX_BITS'(2),
        REG_REPEAT_MIN  = CFG_IDX_BITS'(3)
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                fwd_level;
        logic                bwd_level;
        logic                history_level;
        logic                dump_level;
        logic [CNT_BITS-1:0] entry_count;
    } t_in;

    typedef struct packed {
        logic step_fwd;
        logic step_bwd;
        logic jump_end;
        logic jump_start;
        logic history_toggle;
        logic dump_request;
    } t_out;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_step;
        logic commit;
    } t_ctrl;

endpackage

// ===== rtl/button_click_and_autorepeat.sv =====
// An accepted input passes from IDLE through the DIV state to DONE, where its result
// is registered once the output register is free; no new input is taken before that.
// A restoring divider, one quotient bit per cycle, sets the repeat interval.
// A new input is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) loads register defaults, clears tick, click,
// hold and countdown state and marks all buttons released.
module button_click_and_autorepeat (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bca_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bca_pkg::t_out                      o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bca_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bca_pkg::CFG_BITS-1:0]       i_cfg_data
);

    bca_pkg::t_state r_state, n_state;
    bca_pkg::t_ctrl  s_ctrl;

    logic [bca_pkg::DIV_CNT_BITS-1:0] r_bit_cnt;
    bca_pkg::t_in                     r_item;
    logic [bca_pkg::CNT_BITS-1:0]     r_quo, n_quo;
    logic [bca_pkg::CNT_BITS-1:0]     r_rem, n_rem;
    logic [bca_pkg::CNT_BITS-1:0]     r_div;
    logic [bca_pkg::CNT_BITS:0]       s_rem_sh, s_diff;

    logic [bca_pkg::CFG_BITS-1:0] r_dc_window, r_hold_delay, r_repeat_base, r_repeat_min;

    logic [bca_pkg::TICK_BITS-1:0] r_tick, n_tick;
    logic [3:0]                    r_prev, n_prev;
    logic [bca_pkg::TICK_BITS-1:0] r_last [2];
    logic [bca_pkg::TICK_BITS-1:0] n_last [2];
    logic [1:0]                    r_click [2];
    logic [1:0]                    n_click [2];
    logic [bca_pkg::HOLD_BITS-1:0] r_hold [2];
    logic [bca_pkg::HOLD_BITS-1:0] n_hold [2];
    logic [bca_pkg::CD_BITS-1:0]   r_cd [2];
    logic [bca_pkg::CD_BITS-1:0]   n_cd [2];
    logic [1:0]                    s_step, s_jump;

    bca_pkg::t_out r_out, n_out;
    logic          r_out_valid;

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            bca_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bca_pkg::ST_DIV;
            end
            bca_pkg::ST_DIV: begin
                if (r_bit_cnt == '0) n_state = bca_pkg::ST_DONE;
            end
            bca_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = bca_pkg::ST_IDLE;
            end
            default: n_state = bca_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ctrl = '0;
        case (r_state)
            bca_pkg::ST_IDLE: begin
                s_ctrl.in_ready = 1'b1;
                s_ctrl.load     = i_in_valid;
            end
            bca_pkg::ST_DIV: begin
                s_ctrl.div_step = 1'b1;
            end
            bca_pkg::ST_DONE: begin
                s_ctrl.commit = !r_out_valid || i_out_ready;
            end
            default: s_ctrl = '0;
        endcase
    end

    assign o_in_ready  = s_ctrl.in_ready & i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // restoring divider, one quotient bit per cycle
    always_comb begin
        s_rem_sh = {r_rem, r_quo[bca_pkg::CNT_BITS-1]};
        s_diff   = s_rem_sh - {1'b0, r_div};
        n_rem    = s_diff[bca_pkg::CNT_BITS] ? s_rem_sh[bca_pkg::CNT_BITS-1:0]
                                             : s_diff[bca_pkg::CNT_BITS-1:0];
        n_quo    = {r_quo[bca_pkg::CNT_BITS-2:0], ~s_diff[bca_pkg::CNT_BITS]};
    end

    // per-tick update
    always_comb begin
        logic [3:0]                    cur;
        logic [3:0]                    edges;
        logic [bca_pkg::CD_BITS-1:0]   interval;
        logic [bca_pkg::TICK_BITS-1:0] gap;
        logic [1:0]                    clk_nx;
        logic                          down;
        cur      = {r_item.dump_level, r_item.history_level,
                    r_item.bwd_level, r_item.fwd_level};
        edges    = r_prev & ~cur;
        n_tick   = r_tick + bca_pkg::TICK_BITS'(1);
        n_prev   = cur;
        interval = (r_quo < r_repeat_min) ? r_repeat_min : r_quo;
        for (int d = 0; d < 2; d++) begin
            n_last[d]  = r_last[d];
            n_click[d] = r_click[d];
            n_hold[d]  = r_hold[d];
            n_cd[d]    = r_cd[d];
            s_step[d]  = 1'b0;
            s_jump[d]  = 1'b0;
            down       = !cur[d];
            gap        = n_tick - r_last[d];
            clk_nx     = (gap <= bca_pkg::TICK_BITS'(r_dc_window)) ? r_click[d] + 2'd1 : 2'd1;
            if (edges[d]) begin
                n_last[d] = n_tick;
                if (clk_nx == 2'd2) begin
                    s_jump[d]  = 1'b1;
                    n_click[d] = 2'd0;
                end else begin
                    n_click[d] = clk_nx;
                end
                s_step[d] = 1'b1;
                n_hold[d] = '0;
                n_cd[d]   = r_hold_delay;
            end
            if (down) begin
                if (n_hold[d] != bca_pkg::HOLD_MAX) n_hold[d] = n_hold[d] + 1'b1;
                if (bca_pkg::HCMP_BITS'(n_hold[d]) >= bca_pkg::HCMP_BITS'(r_hold_delay)) begin
                    if (n_cd[d] == '0) begin
                        s_step[d] = 1'b1;
                        n_cd[d]   = interval;
                    end else begin
                        n_cd[d] = n_cd[d] - 1'b1;
                    end
                end
            end else begin
                n_hold[d] = '0;
            end
        end
        n_out.step_fwd       = s_step[0];
        n_out.step_bwd       = s_step[1];
        n_out.jump_end       = s_jump[0];
        n_out.jump_start     = s_jump[1];
        n_out.history_toggle = edges[2];
        n_out.dump_request   = edges[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bca_pkg::ST_IDLE;
            r_bit_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_dc_window   <= bca_pkg::DC_WINDOW_RST;
            r_hold_delay  <= bca_pkg::HOLD_DELAY_RST;
            r_repeat_base <= bca_pkg::REPEAT_BASE_RST;
            r_repeat_min  <= bca_pkg::REPEAT_MIN_RST;
            r_tick        <= '0;
            r_prev        <= 4'hF;
            for (int d = 0; d < 2; d++) begin
                r_last[d]  <= '0;
                r_click[d] <= '0;
                r_hold[d]  <= '0;
                r_cd[d]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bca_pkg::REG_DC_WINDOW:   r_dc_window   <= i_cfg_data;
                    bca_pkg::REG_HOLD_DELAY:  r_hold_delay  <= i_cfg_data;
                    bca_pkg::REG_REPEAT_BASE: r_repeat_base <= i_cfg_data;
                    bca_pkg::REG_REPEAT_MIN:  r_repeat_min  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_ctrl.load) begin
                r_bit_cnt <= bca_pkg::DIV_CNT_BITS'(bca_pkg::CNT_BITS - 1);
            end else if (s_ctrl.div_step) begin
                r_bit_cnt <= r_bit_cnt - 1'b1;
            end
            if (s_ctrl.commit) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_prev      <= n_prev;
                for (int d = 0; d < 2; d++) begin
                    r_last[d]  <= n_last[d];
                    r_click[d] <= n_click[d];
                    r_hold[d]  <= n_hold[d];
                    r_cd[d]    <= n_cd[d];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load) begin
            r_item <= i_in;
            r_quo  <= r_repeat_base;
            r_rem  <= '0;
            r_div  <= (i_in.entry_count == '0) ? bca_pkg::CNT_BITS'(1) : i_in.entry_count;
        end else if (s_ctrl.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (s_ctrl.commit) begin
            r_out <= n_out;
        end
    end

endmodule
